### hw/rtl/lpeg_pkg.sv
// shared types, constants and the sine table generator for the led phase envelope block
package lpeg_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_UPDATE_INTERVAL = 3'd0;
    localparam logic [2:0] REG_PULSE_INTERVAL  = 3'd1;
    localparam logic [2:0] REG_PULSE_LIMIT     = 3'd2;
    localparam logic [2:0] REG_FLASH_LEVEL     = 3'd3;
    localparam logic [2:0] REG_TRIUMPH_MS      = 3'd4;
    localparam logic [2:0] REG_GLOW_MS         = 3'd5;
    localparam logic [2:0] REG_FADE_MS         = 3'd6;

    // reset values of the configuration registers
    localparam logic [15:0] RST_UPDATE_INTERVAL = 16'd20;
    localparam logic [15:0] RST_PULSE_INTERVAL  = 16'd300;
    localparam logic [7:0]  RST_PULSE_LIMIT     = 8'd5;
    localparam logic [7:0]  RST_FLASH_LEVEL     = 8'd255;
    localparam logic [15:0] RST_TRIUMPH_MS      = 16'd2000;
    localparam logic [15:0] RST_GLOW_MS         = 16'd3000;
    localparam logic [15:0] RST_FADE_MS         = 16'd2000;

    // item classes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // envelope stages
    localparam logic [1:0] STAGE_FLASH = 2'd0;
    localparam logic [1:0] STAGE_GLOW  = 2'd1;
    localparam logic [1:0] STAGE_FADE  = 2'd2;

    // envelope arithmetic
    localparam logic [7:0]         DECAY_STEP  = 8'd25;
    localparam logic [7:0]         FADE_TOP    = 8'd200;
    localparam logic [22:0]        GLOW_STEP   = 23'd5468522;
    localparam logic signed [23:0] GLOW_BASE   = 24'sd5570560;
    localparam logic signed [23:0] GLOW_AMP    = 24'sd30;
    localparam logic [7:0]         GREEN_FLASH = 8'd180;
    localparam logic [7:0]         GREEN_GLOW  = 8'd160;
    localparam logic [7:0]         GREEN_FADE  = 8'd140;
    localparam logic [7:0]         BLUE_GLOW   = 8'd20;

    // q30 angle constants for the sine table
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint SINE_DEN [7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                        64'sd110, 64'sd156, 64'sd210};

    typedef struct packed {
        logic [15:0] update_interval;
        logic [15:0] pulse_interval;
        logic [7:0]  pulse_limit;
        logic [7:0]  flash_level;
        logic [15:0] triumph_ms;
        logic [15:0] glow_ms;
        logic [15:0] fade_ms;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
    } t_item;

    // q1.15 sine of a q30 angle in [0, 2pi), taylor series with quadrant folding
    function automatic logic signed [15:0] sine_q15(input longint x_in);
        longint x;
        longint xx;
        longint term;
        longint sum;
        longint r;
        logic   neg;
        x   = x_in;
        neg = 1'b0;
        if (x >= PI_Q30) begin
            x   = x - PI_Q30;
            neg = 1'b1;
        end
        if (x > HALF_PI_Q30) begin
            x = PI_Q30 - x;
        end
        xx   = (x * x) / ONE_Q30;
        term = x;
        sum  = x;
        for (int n = 0; n < 7; n++) begin
            term = (-((term * xx) / ONE_Q30)) / SINE_DEN[n];
            sum  = sum + term;
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum * 64'sd32767 + ONE_Q30 / 2) / ONE_Q30;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        return 16'(neg ? -r : r);
    endfunction

endpackage

### hw/rtl/lpeg_front.sv
// front end: accepts items, classifies them and queues them for the back end
module lpeg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_kind,
    input  logic [31:0]          i_now_ms,
    output logic                 o_q_valid,
    output lpeg_pkg::t_item      o_q_item,
    input  logic                 i_q_pop
);

    lpeg_pkg::t_item r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic            w_push;
    logic            w_pop;

    assign o_stall   = (r_count == 2'd2);
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_mem[r_rptr];
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr].op     <= i_kind ? lpeg_pkg::OP_START : lpeg_pkg::OP_TICK;
            r_mem[r_wptr].now_ms <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_count == 2'd3))
        else $error("queue count beyond two entries");
`endif

endmodule

### hw/rtl/lpeg_div.sv
// restoring divider for the fade ramp, one quotient bit per cycle, eight-bit quotient
module lpeg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [7:0]  o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_cnt;
    logic [23:0] r_rem;
    logic [15:0] r_den;
    logic [7:0]  r_quot;
    logic [23:0] w_trial;
    logic        w_ge;

    assign w_trial = 24'(r_den) << r_cnt;
    assign w_ge    = (r_rem >= w_trial);
    assign o_done  = r_done;
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= 8'd0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - w_trial;
            end
            r_quot <= {r_quot[6:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd7;
            end else if (r_busy) begin
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 3'd1;
                end
            end
        end
    end

endmodule

### hw/rtl/lpeg_back.sv
// back end: envelope state, stage sequencer, sine rom, fade divider and result register
module lpeg_back #(
    parameter int SINE_ENTRIES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lpeg_pkg::t_cfg   i_cfg,
    input  logic             i_q_valid,
    input  lpeg_pkg::t_item  i_q_item,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_level,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [1:0]       o_stage,
    output logic             o_active
);

    localparam int IdxW = $clog2(SINE_ENTRIES);
    localparam int MulW = 32 + $clog2(SINE_ENTRIES + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;
    localparam logic [3:0] ST_EVAL  = 4'd2;
    localparam logic [3:0] ST_MUL1  = 4'd3;
    localparam logic [3:0] ST_MUL2  = 4'd4;
    localparam logic [3:0] ST_ROM   = 4'd5;
    localparam logic [3:0] ST_GLOW  = 4'd6;
    localparam logic [3:0] ST_DIVST = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    // sine rom contents, q1.15
    logic signed [15:0] w_rom [SINE_ENTRIES];

    for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
        localparam longint Ang = (longint'(k) * lpeg_pkg::TWO_PI_Q30) / SINE_ENTRIES;
        assign w_rom[k] = lpeg_pkg::sine_q15(Ang);
    end

    logic [3:0]         r_state;
    lpeg_pkg::t_item    r_item;
    logic [31:0]        r_start_time;
    logic [31:0]        r_last_update;
    logic [31:0]        r_last_flash;
    logic [7:0]         r_level;
    logic [7:0]         r_flash_cnt;
    logic [1:0]         r_stage;
    logic               r_running;
    logic               r_upd_ok;
    logic               r_flash_due;
    logic [31:0]        r_elapsed;
    logic [15:0]        r_off;
    logic [31:0]        r_phase;
    logic [IdxW-1:0]    r_idx;
    logic signed [15:0] r_sine;

    logic               r_out_valid;
    logic [7:0]         r_out_level;
    logic [7:0]         r_out_green;
    logic [7:0]         r_out_blue;
    logic [1:0]         r_out_stage;
    logic               r_out_active;

    logic [16:0]        w_sum_tg;
    logic [17:0]        w_sum_tgf;
    logic [31:0]        w_upd_delta;
    logic [31:0]        w_flash_delta;
    logic [38:0]        w_phase_prod;
    logic [MulW-1:0]    w_idx_prod;
    logic signed [23:0] w_glow_sum;
    logic               w_div_start;
    logic [23:0]        w_div_num;
    logic               w_div_done;
    logic [7:0]         w_div_quot;
    logic [7:0]         w_green_k;
    logic               w_out_free;

    assign w_sum_tg      = 17'(i_cfg.triumph_ms) + 17'(i_cfg.glow_ms);
    assign w_sum_tgf     = 18'(w_sum_tg) + 18'(i_cfg.fade_ms);
    assign w_upd_delta   = r_item.now_ms - r_last_update;
    assign w_flash_delta = r_item.now_ms - r_last_flash;
    assign w_phase_prod  = 39'(r_off) * 39'(GLOW_STEP_W);
    assign w_idx_prod    = MulW'(r_phase) * MulW'(SINE_ENTRIES);
    assign w_glow_sum    = lpeg_pkg::GLOW_BASE + 24'(r_sine) * lpeg_pkg::GLOW_AMP;
    assign w_div_start   = (r_state == ST_DIVST);
    assign w_div_num     = 24'(r_off) * 24'(lpeg_pkg::FADE_TOP);
    assign w_out_free    = !r_out_valid || !i_stall;
    assign o_q_pop       = (r_state == ST_IDLE) && i_q_valid;

    localparam logic [22:0] GLOW_STEP_W = lpeg_pkg::GLOW_STEP;

    always_comb begin
        case (r_stage)
            lpeg_pkg::STAGE_FLASH: w_green_k = lpeg_pkg::GREEN_FLASH;
            lpeg_pkg::STAGE_GLOW:  w_green_k = lpeg_pkg::GREEN_GLOW;
            default:               w_green_k = lpeg_pkg::GREEN_FADE;
        endcase
    end

    lpeg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (i_cfg.fade_ms),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == ST_CHK) begin
            r_upd_ok    <= r_running && (w_upd_delta >= 32'(i_cfg.update_interval));
            r_flash_due <= (w_flash_delta >= 32'(i_cfg.pulse_interval));
            r_elapsed   <= r_item.now_ms - r_start_time;
        end
        if (r_state == ST_EVAL) begin
            if (r_elapsed <= 32'(w_sum_tg)) begin
                r_off <= 16'(r_elapsed - 32'(i_cfg.triumph_ms));
            end else begin
                r_off <= 16'(r_elapsed - 32'(w_sum_tg));
            end
        end
        r_phase <= w_phase_prod[31:0];
        r_idx   <= w_idx_prod[32 +: IdxW];
        r_sine  <= w_rom[r_idx];
    end

    // sequencer and envelope state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_start_time  <= 32'd0;
            r_last_update <= 32'd0;
            r_last_flash  <= 32'd0;
            r_level       <= 8'd0;
            r_flash_cnt   <= 8'd0;
            r_stage       <= lpeg_pkg::STAGE_FLASH;
            r_running     <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (r_item.op == lpeg_pkg::OP_START) begin
                        r_start_time  <= r_item.now_ms;
                        r_last_update <= r_item.now_ms;
                        r_last_flash  <= r_item.now_ms;
                        r_level       <= 8'd0;
                        r_flash_cnt   <= 8'd0;
                        r_stage       <= lpeg_pkg::STAGE_FLASH;
                        r_running     <= 1'b1;
                        r_state       <= ST_IDLE;
                    end else begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (!r_upd_ok) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_last_update <= r_item.now_ms;
                        if (r_elapsed <= 32'(i_cfg.triumph_ms)) begin
                            r_stage <= lpeg_pkg::STAGE_FLASH;
                            if (r_flash_due && (r_flash_cnt < i_cfg.pulse_limit)) begin
                                r_last_flash <= r_item.now_ms;
                                r_flash_cnt  <= r_flash_cnt + 8'd1;
                                r_level      <= i_cfg.flash_level;
                            end else if (r_level > lpeg_pkg::DECAY_STEP) begin
                                r_level <= r_level - lpeg_pkg::DECAY_STEP;
                            end else begin
                                r_level <= 8'd0;
                            end
                            r_state <= ST_OUT;
                        end else if (r_elapsed <= 32'(w_sum_tg)) begin
                            r_stage <= lpeg_pkg::STAGE_GLOW;
                            r_state <= ST_MUL1;
                        end else if ((r_elapsed <= 32'(w_sum_tgf)) &&
                                     (i_cfg.fade_ms != 16'd0)) begin
                            r_stage <= lpeg_pkg::STAGE_FADE;
                            r_state <= ST_DIVST;
                        end else begin
                            r_level   <= 8'd0;
                            r_running <= 1'b0;
                            r_state   <= ST_OUT;
                        end
                    end
                end
                ST_MUL1: r_state <= ST_MUL2;
                ST_MUL2: r_state <= ST_ROM;
                ST_ROM:  r_state <= ST_GLOW;
                ST_GLOW: begin
                    r_level <= w_glow_sum[22:15];
                    r_state <= ST_OUT;
                end
                ST_DIVST: r_state <= ST_DIV;
                ST_DIV: begin
                    if (w_div_done) begin
                        r_level <= lpeg_pkg::FADE_TOP - w_div_quot;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out_level  <= r_level;
            r_out_green  <= div255(16'(r_level) * 16'(w_green_k));
            r_out_blue   <= (r_stage == lpeg_pkg::STAGE_GLOW) ?
                            div255(16'(r_level) * 16'(lpeg_pkg::BLUE_GLOW)) : 8'd0;
            r_out_stage  <= r_stage;
            r_out_active <= r_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_level  = r_out_level;
    assign o_red    = r_out_level;
    assign o_green  = r_out_green;
    assign o_blue   = r_out_blue;
    assign o_stage  = r_out_stage;
    assign o_active = r_out_active;

`ifndef SYNTHESIS
    a_stage_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_stage == lpeg_pkg::STAGE_FLASH ||
                         r_out_stage == lpeg_pkg::STAGE_GLOW ||
                         r_out_stage == lpeg_pkg::STAGE_FADE))
        else $error("result carries an undefined stage");
    a_glow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_active && r_out_stage == lpeg_pkg::STAGE_GLOW)
        |-> (r_out_level >= 8'd140 && r_out_level <= 8'd199))
        else $error("glow level outside 140..199");
    a_done_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_active) |-> (r_out_level == 8'd0 && r_out_green == 8'd0))
        else $error("final result is not dark");
`endif

endmodule

### hw/rtl/led_phase_envelope_gen.sv
// top level of the led phase envelope generator: config registers, front end and back end
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_kind, i_now_ms
//  result    out        o_valid / i_stall   o_level, o_red, o_green, o_blue, o_stage, o_active
//  config    in         apb psel / penable  paddr, pwdata, prdata (pready tied high)
//
// a start transfer passes through the back end states idle and check, a tick with no result on to eval
// a flash update then outputs, a glow update first does two multiplies and the sine rom read,
// a fade update first runs the eight-step divider
// the two-entry queue takes input transfers while the back end works or the result waits, until full
// reset is synchronous, active low; it restores register defaults and disarms the envelope
// a stalled result holds in the output register; the back end waits before writing the next one
module led_phase_envelope_gen #(
    parameter int SINE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transfers
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [31:0] i_now_ms,
    // result transfers
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_level,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [1:0]  o_stage,
    output logic        o_active,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lpeg_pkg::t_cfg  r_cfg;
    lpeg_pkg::t_item w_q_item;
    logic            w_q_valid;
    logic            w_q_pop;
    logic            w_wr;
    logic [2:0]      w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_wr      = psel && penable && pwrite && pready;

    // register writes, out-of-range index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.update_interval <= lpeg_pkg::RST_UPDATE_INTERVAL;
            r_cfg.pulse_interval  <= lpeg_pkg::RST_PULSE_INTERVAL;
            r_cfg.pulse_limit     <= lpeg_pkg::RST_PULSE_LIMIT;
            r_cfg.flash_level     <= lpeg_pkg::RST_FLASH_LEVEL;
            r_cfg.triumph_ms      <= lpeg_pkg::RST_TRIUMPH_MS;
            r_cfg.glow_ms         <= lpeg_pkg::RST_GLOW_MS;
            r_cfg.fade_ms         <= lpeg_pkg::RST_FADE_MS;
        end else if (w_wr) begin
            case (w_reg_idx)
                lpeg_pkg::REG_UPDATE_INTERVAL: r_cfg.update_interval <= pwdata[15:0];
                lpeg_pkg::REG_PULSE_INTERVAL:  r_cfg.pulse_interval  <= pwdata[15:0];
                lpeg_pkg::REG_PULSE_LIMIT:     r_cfg.pulse_limit     <= pwdata[7:0];
                lpeg_pkg::REG_FLASH_LEVEL:     r_cfg.flash_level     <= pwdata[7:0];
                lpeg_pkg::REG_TRIUMPH_MS:      r_cfg.triumph_ms      <= pwdata[15:0];
                lpeg_pkg::REG_GLOW_MS:         r_cfg.glow_ms         <= pwdata[15:0];
                lpeg_pkg::REG_FADE_MS:         r_cfg.fade_ms         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            lpeg_pkg::REG_UPDATE_INTERVAL: prdata = 32'(r_cfg.update_interval);
            lpeg_pkg::REG_PULSE_INTERVAL:  prdata = 32'(r_cfg.pulse_interval);
            lpeg_pkg::REG_PULSE_LIMIT:     prdata = 32'(r_cfg.pulse_limit);
            lpeg_pkg::REG_FLASH_LEVEL:     prdata = 32'(r_cfg.flash_level);
            lpeg_pkg::REG_TRIUMPH_MS:      prdata = 32'(r_cfg.triumph_ms);
            lpeg_pkg::REG_GLOW_MS:         prdata = 32'(r_cfg.glow_ms);
            lpeg_pkg::REG_FADE_MS:         prdata = 32'(r_cfg.fade_ms);
            default:                       prdata = 32'd0;
        endcase
    end

    // front end: classify and queue incoming transfers
    lpeg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_kind    (i_kind),
        .i_now_ms  (i_now_ms),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    // back end: envelope sequencer and result register
    lpeg_back #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_level   (o_level),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue),
        .o_stage   (o_stage),
        .o_active  (o_active)
    );

endmodule

### verif/led_phase_envelope_gen_test.sv
// self-checking testbench for the led phase envelope generator with its own envelope predictor
module led_phase_envelope_gen_test;
    import lpeg_pkg::*;

    localparam int SINE_ENTRIES  = 256;
    localparam int HALF_PERIOD   = 5;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 148;
    localparam int DRAIN_CYCLES  = 40;
    localparam int QUIET_LIMIT   = 3000;

    // unused hole in the register map, writes must be ignored
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // envelope arithmetic
    localparam int     LEVEL_DECAY = 25;
    localparam int     RAMP_TOP    = 200;
    localparam int     GLOW_MID    = 170;
    localparam int     GLOW_SWING  = 30;
    localparam longint PHASE_STEP  = 64'd5468522;

    // q30 angles for the sine rom contents
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;

    typedef struct {
        bit [15:0] update_interval;
        bit [15:0] pulse_interval;
        bit [7:0]  pulse_limit;
        bit [7:0]  flash_level;
        bit [15:0] triumph_ms;
        bit [15:0] glow_ms;
        bit [15:0] fade_ms;
    } knobs_t;

    typedef struct {
        bit [7:0] level;
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit [1:0] stage;
        bit       active;
    } led_out_t;

    // how a directed row gets its expectation
    typedef enum {ROW_PRED, ROW_NONE, ROW_TYPED} row_e;

    typedef struct {
        logic        kind;
        logic [31:0] now;
        row_e        how;
        bit [7:0]    level;
        bit [7:0]    green;
        bit [7:0]    blue;
        bit [1:0]    stage;
        bit          active;
    } row_t;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic        o_stall;
    logic        i_kind   = 1'b0;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_stall  = 1'b0;
    logic [7:0]  o_level;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [1:0]  o_stage;
    logic        o_active;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    led_phase_envelope_gen #(
        .SINE_ENTRIES(SINE_ENTRIES)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .i_now_ms (i_now_ms),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_level  (o_level),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue),
        .o_stage  (o_stage),
        .o_active (o_active),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // predictor copy of the registers, at their reset values
    knobs_t knobs = '{16'd20, 16'd300, 8'd5, 8'd255, 16'd2000, 16'd3000, 16'd2000};

    // predictor copy of the envelope state
    bit [31:0] seq_start  = '0;
    bit [31:0] upd_last   = '0;
    bit [31:0] flash_last = '0;
    bit [7:0]  env_level  = '0;
    bit [7:0]  flash_num  = '0;
    bit [1:0]  env_stage  = STAGE_FLASH;
    bit        env_armed  = 1'b0;

    int       sine_rom [SINE_ENTRIES];
    led_out_t pending_levels [$];
    led_out_t want;

    bit calm          = 1'b0;
    int items_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int settings_used = 1;
    int quiet         = 0;
    int stall_left    = 0;

    // directed part: runs on the reset register values
    row_t directed_rows [22] = '{
        '{OP_TICK,  32'd0,          ROW_NONE,  8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0},
        '{OP_START, 32'd100,        ROW_NONE,  8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0},
        '{OP_TICK,  32'd110,        ROW_NONE,  8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0},
        '{OP_TICK,  32'd120,        ROW_TYPED, 8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b1},
        '{OP_TICK,  32'd400,        ROW_TYPED, 8'd255, 8'd180, 8'd0,  STAGE_FLASH, 1'b1},
        '{OP_TICK,  32'd420,        ROW_TYPED, 8'd230, 8'd162, 8'd0,  STAGE_FLASH, 1'b1},
        '{OP_TICK,  32'd1000,       ROW_PRED,  8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0},
        '{OP_TICK,  32'd2080,       ROW_PRED,  8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0},
        '{OP_TICK,  32'd2101,       ROW_TYPED, 8'd170, 8'd106, 8'd13, STAGE_GLOW,  1'b1},
        '{OP_TICK,  32'd5100,       ROW_PRED,  8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0},
        '{OP_TICK,  32'd5120,       ROW_TYPED, 8'd198, 8'd108, 8'd0,  STAGE_FADE,  1'b1},
        '{OP_TICK,  32'd7100,       ROW_TYPED, 8'd0,   8'd0,   8'd0,  STAGE_FADE,  1'b1},
        '{OP_TICK,  32'd7120,       ROW_TYPED, 8'd0,   8'd0,   8'd0,  STAGE_FADE,  1'b0},
        '{OP_TICK,  32'd7200,       ROW_NONE,  8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0},
        '{OP_START, 32'hFFFF_FF00,  ROW_NONE,  8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0},
        '{OP_TICK,  32'hFFFF_FFFF,  ROW_TYPED, 8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b1},
        '{OP_TICK,  32'h0000_002C,  ROW_TYPED, 8'd255, 8'd180, 8'd0,  STAGE_FLASH, 1'b1},
        '{OP_START, 32'h0000_0040,  ROW_NONE,  8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0},
        '{OP_TICK,  32'h0000_0050,  ROW_NONE,  8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0},
        '{OP_TICK,  32'h0000_0054,  ROW_TYPED, 8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b1},
        '{OP_TICK,  32'hFFFF_FFFF,  ROW_TYPED, 8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0},
        '{OP_TICK,  32'h7FFF_FFFF,  ROW_NONE,  8'd0,   8'd0,   8'd0,  STAGE_FLASH, 1'b0}
    };

    // q1.15 sine rom entry, taylor series on a folded q30 angle
    function automatic int sine_rom_entry(input int k);
        longint ang;
        longint sq;
        longint term;
        longint acc;
        longint r;
        bit     neg;
        ang = (longint'(k) * Q30_TWO_PI) / SINE_ENTRIES;
        neg = 1'b0;
        if (ang >= Q30_PI) begin
            ang = ang - Q30_PI;
            neg = 1'b1;
        end
        if (ang > Q30_HALF_PI) begin
            ang = Q30_PI - ang;
        end
        sq   = (ang * ang) / Q30_ONE;
        term = ang;
        acc  = ang;
        for (int n = 1; n <= 7; n++) begin
            term = -((term * sq) / Q30_ONE) / longint'((2 * n) * (2 * n + 1));
            acc  = acc + term;
        end
        if (acc < 0) begin
            acc = 0;
        end
        r = (acc * 32767 + Q30_ONE / 2) / Q30_ONE;
        if (r > 32767) begin
            r = 32767;
        end
        return neg ? -int'(r) : int'(r);
    endfunction

    // envelope predictor: advances the state on one transfer, returns 1 when a result is due
    function automatic bit envelope_next(input logic kind, input logic [31:0] now,
                                         output led_out_t r);
        bit [31:0]   gap;
        bit [31:0]   elapsed;
        bit [31:0]   glow_end;
        bit [31:0]   fade_end;
        bit [31:0]   t;
        bit [63:0]   phase;
        int          idx;
        int          v;
        int unsigned gscale;
        r = '{default: '0};
        if (kind == OP_START) begin
            seq_start  = now;
            upd_last   = now;
            flash_last = now;
            env_level  = '0;
            flash_num  = '0;
            env_stage  = STAGE_FLASH;
            env_armed  = 1'b1;
            return 1'b0;
        end
        if (!env_armed) begin
            return 1'b0;
        end
        gap = now - upd_last;
        if (gap < 32'(knobs.update_interval)) begin
            return 1'b0;
        end
        upd_last = now;
        elapsed  = now - seq_start;
        glow_end = 32'(knobs.triumph_ms) + 32'(knobs.glow_ms);
        fade_end = glow_end + 32'(knobs.fade_ms);
        if (elapsed <= 32'(knobs.triumph_ms)) begin
            env_stage = STAGE_FLASH;
            gap = now - flash_last;
            if (gap >= 32'(knobs.pulse_interval) && flash_num < knobs.pulse_limit) begin
                flash_last = now;
                flash_num  = flash_num + 8'd1;
                env_level  = knobs.flash_level;
            end else begin
                env_level = (env_level > LEVEL_DECAY) ? env_level - 8'(LEVEL_DECAY) : 8'd0;
            end
        end else if (elapsed <= glow_end) begin
            // phase is a q0.32 fraction of a turn, the top bits pick the rom entry
            env_stage = STAGE_GLOW;
            t     = elapsed - 32'(knobs.triumph_ms);
            phase = (64'(t) * PHASE_STEP) & 64'hFFFF_FFFF;
            idx   = int'((phase * SINE_ENTRIES) >> 32);
            v     = (GLOW_MID << 15) + GLOW_SWING * sine_rom[idx];
            env_level = 8'(v >>> 15);
        end else if (elapsed <= fade_end && knobs.fade_ms != 0) begin
            env_stage = STAGE_FADE;
            t = elapsed - glow_end;
            env_level = 8'(RAMP_TOP - (RAMP_TOP * t) / knobs.fade_ms);
        end else begin
            // sequence over, the stage keeps its last value
            env_level = '0;
            env_armed = 1'b0;
        end
        gscale = (env_stage == STAGE_FLASH) ? 180 : (env_stage == STAGE_GLOW) ? 160 : 140;
        r.level  = env_level;
        r.red    = env_level;
        r.green  = 8'((int'(env_level) * gscale) / 255);
        r.blue   = (env_stage == STAGE_GLOW) ? 8'((int'(env_level) * 20) / 255) : 8'd0;
        r.stage  = env_stage;
        r.active = env_armed;
        return 1'b1;
    endfunction

    // idle run length: mostly none, sometimes a few cycles, rarely a long one
    function automatic int idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return 0;
        end else if (pick < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // distance to the next tick: early, on time, a jump into a later stage, or anywhere
    function automatic bit [31:0] tick_step(input bit [31:0] upd, input bit [31:0] span);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            return $urandom_range(0, upd);
        end else if (pick < 85) begin
            return upd + $urandom_range(0, upd / 4 + 3);
        end else if (pick < 97) begin
            return $urandom_range(0, span / 4 + 1);
        end
        return $urandom();
    endfunction

    task automatic check_field(input string what, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expected, actual);
            mismatches++;
        end
    endtask

    // drive one input transfer and run the predictor once it is taken
    task automatic offer_item(input logic kind, input logic [31:0] now,
                              output bit made, output led_out_t pred);
        int gap;
        gap = calm ? 0 : idle_length();
        repeat (gap) @(negedge i_clk) i_valid <= 1'b0;
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_now_ms <= now;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        made = envelope_next(kind, now, pred);
    endtask

    task automatic feed(input logic kind, input logic [31:0] now);
        bit       made;
        led_out_t pred;
        offer_item(kind, now, made, pred);
        if (made) begin
            pending_levels.push_back(pred);
        end
    endtask

    // drop valid, wait for every expected result, then let any result-free tick finish
    task automatic settle();
        @(negedge i_clk) i_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write followed by a read back of the same register
    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        logic [31:0] keep;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        keep = '0;
        case (idx)
            REG_UPDATE_INTERVAL: begin
                knobs.update_interval = data[15:0];
                keep = 32'(data[15:0]);
            end
            REG_PULSE_INTERVAL: begin
                knobs.pulse_interval = data[15:0];
                keep = 32'(data[15:0]);
            end
            REG_PULSE_LIMIT: begin
                knobs.pulse_limit = data[7:0];
                keep = 32'(data[7:0]);
            end
            REG_FLASH_LEVEL: begin
                knobs.flash_level = data[7:0];
                keep = 32'(data[7:0]);
            end
            REG_TRIUMPH_MS: begin
                knobs.triumph_ms = data[15:0];
                keep = 32'(data[15:0]);
            end
            REG_GLOW_MS: begin
                knobs.glow_ms = data[15:0];
                keep = 32'(data[15:0]);
            end
            REG_FADE_MS: begin
                knobs.fade_ms = data[15:0];
                keep = 32'(data[15:0]);
            end
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx != REG_UNUSED && prdata !== keep) begin
            $display("%0t: register %0d read back, expected %0d, actual %0d",
                     $time, idx, keep, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper bits carry junk, only the register width may stick
    task automatic load_knobs(input knobs_t k);
        write_register(REG_UPDATE_INTERVAL, {16'($urandom()), k.update_interval});
        write_register(REG_PULSE_INTERVAL,  {16'($urandom()), k.pulse_interval});
        write_register(REG_PULSE_LIMIT,     {24'($urandom()), k.pulse_limit});
        write_register(REG_FLASH_LEVEL,     {24'($urandom()), k.flash_level});
        write_register(REG_TRIUMPH_MS,      {16'($urandom()), k.triumph_ms});
        write_register(REG_GLOW_MS,         {16'($urandom()), k.glow_ms});
        write_register(REG_FADE_MS,         {16'($urandom()), k.fade_ms});
    endtask

    // receiver side stalls, set at the falling edge
    always @(negedge i_clk) begin
        if (stall_left == 0 && !calm) begin
            stall_left = idle_length();
        end
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result checker: every taken result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_levels.size() == 0) begin
                $display("%0t: unexpected result, level %0d stage %0d active %0d",
                         $time, o_level, o_stage, o_active);
                mismatches++;
            end else begin
                want = pending_levels.pop_front();
                check_field("level",  want.level,  o_level);
                check_field("red",    want.red,    o_red);
                check_field("green",  want.green,  o_green);
                check_field("blue",   want.blue,   o_blue);
                check_field("stage",  want.stage,  o_stage);
                check_field("active", want.active, o_active);
            end
        end
    end

    // watchdog on cycles with no transfer on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable && pready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet == QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, pending_levels.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        knobs_t      k;
        bit [31:0]   now;
        bit [31:0]   span;
        int          burst;
        int          target;
        bit          made;
        led_out_t    pred;
        for (int e = 0; e < SINE_ENTRIES; e++) begin
            sine_rom[e] = sine_rom_entry(e);
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed rows on the reset register values
        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i].kind, directed_rows[i].now, made, pred);
            case (directed_rows[i].how)
                ROW_TYPED: begin
                    pending_levels.push_back('{directed_rows[i].level, directed_rows[i].level,
                                               directed_rows[i].green, directed_rows[i].blue,
                                               directed_rows[i].stage,
                                               directed_rows[i].active});
                end
                ROW_PRED: begin
                    if (made) begin
                        pending_levels.push_back(pred);
                    end
                end
                default: ;
            endcase
        end
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                // zero update and pulse intervals, fade stage skipped
                0: k = '{16'd0, 16'd0, 8'd3, 8'd255, 16'd10, 16'd30, 16'd0};
                // low extremes: no flashes, empty flash and glow stages, one-ms fade
                1: k = '{16'd1, 16'd1, 8'd0, 8'd0, 16'd0, 16'd0, 16'd1};
                // high extremes
                2: k = '{16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                default: begin
                    case ($urandom_range(0, 9))
                        0:       k.update_interval = 16'd0;
                        9:       k.update_interval = 16'd20;
                        default: k.update_interval = 16'($urandom_range(1, 8));
                    endcase
                    k.pulse_interval = 16'($urandom_range(0, 60));
                    k.pulse_limit    = ($urandom_range(0, 3) == 0) ? 8'hFF :
                                       8'($urandom_range(0, 12));
                    k.flash_level    = 8'($urandom());
                    k.triumph_ms     = 16'($urandom_range(0, 400));
                    k.glow_ms        = 16'($urandom_range(0, 800));
                    k.fade_ms        = ($urandom_range(0, 4) == 0) ? 16'd0 :
                                       16'($urandom_range(1, 400));
                end
            endcase
            load_knobs(k);
            if (ph == 0) begin
                write_register(REG_UNUSED, $urandom());
            end
            settings_used++;
            calm = (ph % 4 == 3);

            span   = 32'(k.triumph_ms) + 32'(k.glow_ms) + 32'(k.fade_ms);
            target = items_sent + PHASE_ITEMS;
            now    = $urandom();
            while (items_sent < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    // stray tick or restart at an arbitrary time
                    now = $urandom();
                    feed(logic'($urandom_range(0, 1)), now);
                end else begin
                    // a start and a run of ticks long enough to reach the end mostly
                    feed(OP_START, now);
                    burst = int'(span / (32'(k.update_interval) + 2)) + $urandom_range(1, 8);
                    if (burst > 90) begin
                        burst = 90;
                    end
                    for (int j = 0; j < burst && items_sent < target; j++) begin
                        now = now + tick_step(32'(k.update_interval), span);
                        feed(OP_TICK, now);
                    end
                end
            end
            settle();
        end
        calm = 1'b0;

        $display("%0d input transfers, %0d results checked over %0d register settings",
                 items_sent, results_seen, settings_used);
        $display("all three stages, wrap of the ms counter and zero registers exercised");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
